// File: src/pisd_pkg.sv
package pisd_pkg;

    localparam int HEADER_BYTES    = 32;
    localparam int PALETTE_ENTRIES = 16;

    localparam int POS_W       = 6;
    localparam int SIZE_W      = 32;
    localparam int CFG_SIZE_W  = 24;
    localparam int COUNT_W     = 8;
    localparam int PANEL_W     = 4;
    localparam int PAL_ADDR_W  = 4;

    localparam logic [CFG_SIZE_W-1:0] EXPECTED_SIZE_RESET = 24'd960000;

    // Header layout: size in bytes 0..3, colour count in byte 8, palette in 16..31.
    localparam logic [POS_W-1:0] SIZE_FIELD_END    = 6'd4;
    localparam logic [POS_W-1:0] COUNT_FIELD_POS   = 6'd8;
    localparam logic [POS_W-1:0] PALETTE_FIELD_POS = 6'd16;
    localparam logic [POS_W-1:0] HEADER_END        = 6'd32;

    localparam logic [COUNT_W-1:0] MIN_COLOURS = 8'd2;
    localparam logic [COUNT_W-1:0] MAX_COLOURS = 8'd6;

    localparam logic [7:0] COLOR_BLACK  = 8'h00;
    localparam logic [7:0] COLOR_WHITE  = 8'hFF;
    localparam logic [7:0] COLOR_YELLOW = 8'hFC;
    localparam logic [7:0] COLOR_RED    = 8'hE0;
    localparam logic [7:0] COLOR_BLUE   = 8'h03;
    localparam logic [7:0] COLOR_GREEN  = 8'h1C;

    typedef logic [PANEL_W-1:0]    panel_code_t;
    typedef logic [PAL_ADDR_W-1:0] pal_addr_t;

    localparam panel_code_t PANEL_BLACK  = 4'd0;
    localparam panel_code_t PANEL_WHITE  = 4'd1;
    localparam panel_code_t PANEL_YELLOW = 4'd2;
    localparam panel_code_t PANEL_RED    = 4'd3;
    localparam panel_code_t PANEL_BLUE   = 4'd5;
    localparam panel_code_t PANEL_GREEN  = 4'd6;

    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_ACCEPTED  = 2'd1,
        KIND_BAD_COUNT = 2'd2,
        KIND_BAD_SIZE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
    } out_beat_t;

    typedef struct packed {
        logic        en;
        pal_addr_t   addr;
        panel_code_t code;
    } pal_wr_t;

    typedef struct packed {
        logic      en;
        pal_addr_t addr_hi;
        pal_addr_t addr_lo;
    } pal_rd_t;

    function automatic panel_code_t panel_code(input logic [7:0] color);
        panel_code_t code;
        case (color)
            COLOR_BLACK:  code = PANEL_BLACK;
            COLOR_WHITE:  code = PANEL_WHITE;
            COLOR_YELLOW: code = PANEL_YELLOW;
            COLOR_RED:    code = PANEL_RED;
            COLOR_BLUE:   code = PANEL_BLUE;
            COLOR_GREEN:  code = PANEL_GREEN;
            default:      code = PANEL_BLACK;
        endcase
        return code;
    endfunction

endpackage

// File: src/pisd_palette.sv
module pisd_palette (
    input  logic                  aclk,
    input  pisd_pkg::pal_wr_t     wr,
    input  pisd_pkg::pal_rd_t     rd,
    output pisd_pkg::panel_code_t code_hi,
    output pisd_pkg::panel_code_t code_lo
);
    import pisd_pkg::*;

    panel_code_t mem [PALETTE_ENTRIES];
    panel_code_t code_hi_reg;
    panel_code_t code_lo_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.code;
        end
    end

    // Both pixel nibbles are looked up in the same cycle.
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            code_hi_reg <= mem[rd.addr_hi];
            code_lo_reg <= mem[rd.addr_lo];
        end
    end

    assign code_hi = code_hi_reg;
    assign code_lo = code_lo_reg;

endmodule

// File: src/palette_image_stream_decoder.sv
// Palette image stream decoder.
// The input channel (s_valid/s_ready/s_data) carries one file byte per beat;
// file_start marks the first header byte of a new file. The first 32 bytes
// form the header: file size, colour count and a 16-entry palette, each
// palette color being mapped to a panel code as it arrives. The last header
// byte produces one status beat (accepted, bad colour count or bad size).
// After an accepted header, every byte yields one output beat holding two
// panel codes, high nibble for the first pixel. After a rejected header,
// bytes yield nothing until the next file start.
// A result beat appears on m_valid/m_data in the cycle after its byte is taken;
// the result register, loaded together with the registered palette reads, is
// the only stage. One byte is taken per cycle unless a stalled result beat,
// held until taken, drops s_ready. expected_size is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, which the
// block does not enforce. Reset clears the header position and blocks pixel
// output; the palette holds nothing meaningful until a header fills it.
module palette_image_stream_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [23:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  pisd_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pisd_pkg::out_beat_t m_data
);
    import pisd_pkg::*;

    logic [CFG_SIZE_W-1:0] expected_size_reg;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [SIZE_W-1:0]     size_acc_reg, size_acc_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  allowed_reg, allowed_next;
    logic                  m_valid_reg, m_valid_next;
    kind_t                 kind_reg, kind_next;

    logic             s_fire;
    logic [POS_W-1:0] pos_eff;
    logic             allowed_eff;
    logic             in_header;
    logic             header_done;
    logic [7:0]       b;
    pal_wr_t          pal_wr;
    pal_rd_t          pal_rd;
    panel_code_t      code_hi;
    panel_code_t      code_lo;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign b       = s_data.data_byte;

    // A file start restarts the header on this very byte.
    assign pos_eff     = s_data.file_start ? '0 : pos_reg;
    assign allowed_eff = s_data.file_start ? 1'b0 : allowed_reg;
    assign in_header   = pos_eff < HEADER_END;
    assign header_done = in_header && ((pos_eff + 6'd1) == HEADER_END);

    always_comb begin
        pos_next      = pos_reg;
        size_acc_next = size_acc_reg;
        count_next    = count_reg;
        allowed_next  = allowed_reg;
        kind_next     = kind_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (s_fire) begin
            allowed_next = allowed_eff;
            m_valid_next = 1'b0;
            if (in_header) begin
                pos_next = pos_eff + 6'd1;
                if (pos_eff < SIZE_FIELD_END) begin
                    case (pos_eff[1:0])
                        2'd0:    size_acc_next = {24'd0, b};
                        2'd1:    size_acc_next = size_acc_reg | {16'd0, b, 8'd0};
                        2'd2:    size_acc_next = size_acc_reg | {8'd0, b, 16'd0};
                        default: size_acc_next = size_acc_reg | {b, 24'd0};
                    endcase
                end
                if (pos_eff == COUNT_FIELD_POS) begin
                    count_next = b;
                end
                if (header_done) begin
                    m_valid_next = 1'b1;
                    if (count_reg < MIN_COLOURS || count_reg > MAX_COLOURS) begin
                        kind_next = KIND_BAD_COUNT;
                    end else if (size_acc_reg != {8'd0, expected_size_reg}) begin
                        kind_next = KIND_BAD_SIZE;
                    end else begin
                        kind_next    = KIND_ACCEPTED;
                        allowed_next = 1'b1;
                    end
                end
            end else if (allowed_eff) begin
                m_valid_next = 1'b1;
                kind_next    = KIND_PIXEL;
            end
        end
    end

    always_comb begin
        pal_wr.en      = s_fire && in_header && (pos_eff[5:4] == PALETTE_FIELD_POS[5:4]);
        pal_wr.addr    = pos_eff[PAL_ADDR_W-1:0];
        pal_wr.code    = panel_code(b);
        pal_rd.en      = s_fire && !in_header && allowed_eff;
        pal_rd.addr_hi = b[7:4];
        pal_rd.addr_lo = b[3:0];
    end

    pisd_palette u_palette (
        .aclk    (aclk),
        .wr      (pal_wr),
        .rd      (pal_rd),
        .code_hi (code_hi),
        .code_lo (code_lo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_size_reg <= EXPECTED_SIZE_RESET;
            pos_reg           <= '0;
            size_acc_reg      <= '0;
            count_reg         <= '0;
            allowed_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
            kind_reg          <= KIND_PIXEL;
        end else begin
            if (cfg_wr_en) begin
                expected_size_reg <= cfg_wr_data;
            end
            pos_reg      <= pos_next;
            size_acc_reg <= size_acc_next;
            count_reg    <= count_next;
            allowed_reg  <= allowed_next;
            m_valid_reg  <= m_valid_next;
            kind_reg     <= kind_next;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        m_data.kind     = kind_reg;
        m_data.out_byte = (kind_reg == KIND_PIXEL) ? {code_hi, code_lo} : 8'd0;
    end

    // The header position stops at the end of the header.
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= HEADER_END)
        else $error("header position ran past the header");

    // A file start always makes the byte header byte zero.
    a_file_start_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.file_start) |=> (pos_reg == 6'd1) && !allowed_reg)
        else $error("file start did not restart the header");

    // Past the header with pixels blocked, a byte gives no result.
    a_blocked_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_data.file_start && pos_reg == HEADER_END && !allowed_reg)
        |=> !m_valid_reg)
        else $error("pixel beat produced after a rejected header");

    // An accepted header opens the pixel path.
    a_accept_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && header_done && kind_next == KIND_ACCEPTED)
        |=> allowed_reg && m_valid_reg)
        else $error("accepted header did not enable pixels");

endmodule
